[design/tfm_pkg.sv]
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared widths, register map and pipeline types of the trapezoid fuzzifier.
// ----------------------------------------------------------------------------
package tfm_pkg;

  localparam int VALUE_WIDTH   = 16;
  localparam int FRACTION_BITS = 15;
  localparam int GRADE_WIDTH   = FRACTION_BITS + 1;
  localparam int ADDR_WIDTH    = 4;
  localparam int DATA_WIDTH    = 32;
  localparam int DIV_STAGES    = FRACTION_BITS;

  localparam logic [GRADE_WIDTH-1:0] GRADE_ONE = GRADE_WIDTH'(1) << FRACTION_BITS;

  localparam logic [1:0] REG_LEFT_EDGE  = 2'd0;
  localparam logic [1:0] REG_RISE_END   = 2'd1;
  localparam logic [1:0] REG_FALL_START = 2'd2;
  localparam logic [1:0] REG_RIGHT_EDGE = 2'd3;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_DIV
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic                      in_support;
    logic [VALUE_WIDTH-1:0]    rem;
    logic [VALUE_WIDTH-1:0]    den;
    logic [FRACTION_BITS-1:0]  quo;
  } stage_t;

endpackage

[design/trapezoid_fuzzy_membership_unit.sv]
// ----------------------------------------------------------------------------
// trapezoid_fuzzy_membership_unit
// Trapezoidal membership grade of a signed sample, Q1.15, pipelined divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample_i with in_valid_i / in_stall_o. A beat is taken on
//   a rising edge with valid high and stall low.
//   Output channel: grade_o, in_support_o with out_valid_o / out_stall_i.
//   Breakpoints are written over the APB port (left_edge 0x0, rise_end 0x4,
//   fall_start 0x8, right_edge 0xC); the user must write them only while
//   the pipe is empty, the block does not enforce it. Stages: one compare
//   stage, one per quotient bit of the restoring divider, one output stage.
//   Throughput: one beat per cycle unless stalled; one bit per divider stage.
//   Stall: the whole pipe holds while a result waits on out_stall_i; the
//   held result and every stage keep their contents, nothing is dropped.
//   Reset: all valid bits clear, breakpoints return to 0.
// ----------------------------------------------------------------------------
module trapezoid_fuzzy_membership_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tfm_pkg::ADDR_WIDTH-1:0]        paddr,
  input  logic [tfm_pkg::DATA_WIDTH-1:0]        pwdata,
  output logic [tfm_pkg::DATA_WIDTH-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tfm_pkg::VALUE_WIDTH-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tfm_pkg::GRADE_WIDTH-1:0]       grade_o,
  output logic                                  in_support_o
);
  import tfm_pkg::*;

  logic signed [VALUE_WIDTH-1:0] left_q, rise_q, fall_q, right_q;
  logic                          cfg_we;
  logic [1:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      rise_q  <= '0;
      fall_q  <= '0;
      right_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LEFT_EDGE:  left_q  <= pwdata[VALUE_WIDTH-1:0];
        REG_RISE_END:   rise_q  <= pwdata[VALUE_WIDTH-1:0];
        REG_FALL_START: fall_q  <= pwdata[VALUE_WIDTH-1:0];
        REG_RIGHT_EDGE: right_q <= pwdata[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_LEFT_EDGE:  prdata[VALUE_WIDTH-1:0] = left_q;
      REG_RISE_END:   prdata[VALUE_WIDTH-1:0] = rise_q;
      REG_FALL_START: prdata[VALUE_WIDTH-1:0] = fall_q;
      REG_RIGHT_EDGE: prdata[VALUE_WIDTH-1:0] = right_q;
      default: ;
    endcase
  end

  // global advance: the pipe moves unless a result is held
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // entry stage: branch select and operands
  logic signed [VALUE_WIDTH:0] t_x, a_x, b_x, c_x, d_x;
  logic signed [VALUE_WIDTH:0] rise_num, rise_den, fall_num, fall_den;
  stage_t                      entry_d;

  always_comb begin
    t_x      = {sample_i[VALUE_WIDTH-1], sample_i};
    a_x      = {left_q[VALUE_WIDTH-1], left_q};
    b_x      = {rise_q[VALUE_WIDTH-1], rise_q};
    c_x      = {fall_q[VALUE_WIDTH-1], fall_q};
    d_x      = {right_q[VALUE_WIDTH-1], right_q};
    rise_num = t_x - a_x;
    rise_den = b_x - a_x;
    fall_num = d_x - t_x;
    fall_den = d_x - c_x;
    entry_d            = '0;
    entry_d.in_support = (t_x >= a_x) && (t_x <= d_x);
    entry_d.mode       = MODE_ZERO;
    if (t_x <= a_x) begin
      entry_d.mode = MODE_ZERO;
    end else if (t_x < b_x) begin
      entry_d.mode = MODE_DIV;
      entry_d.rem  = rise_num[VALUE_WIDTH-1:0];
      entry_d.den  = rise_den[VALUE_WIDTH-1:0];
    end else if (t_x <= c_x) begin
      entry_d.mode = MODE_FULL;
    end else if (t_x < d_x) begin
      entry_d.mode = MODE_DIV;
      entry_d.rem  = fall_num[VALUE_WIDTH-1:0];
      entry_d.den  = fall_den[VALUE_WIDTH-1:0];
    end
  end

  stage_t stg_q [DIV_STAGES+1];
  logic   vld_q [DIV_STAGES+1];
  stage_t stg_d [DIV_STAGES+1];

  always_comb begin
    stg_d[0] = entry_d;
  end

  // one restoring-division step per stage, remainder stays below den
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [VALUE_WIDTH:0] dbl;
    logic [VALUE_WIDTH:0] diff;
    logic                 quo_bit;
    always_comb begin
      dbl      = {stg_q[k-1].rem, 1'b0};
      diff     = dbl - {1'b0, stg_q[k-1].den};
      quo_bit  = !diff[VALUE_WIDTH];
      stg_d[k] = stg_q[k-1];
      stg_d[k].rem = quo_bit ? diff[VALUE_WIDTH-1:0] : dbl[VALUE_WIDTH-1:0];
      stg_d[k].quo = {stg_q[k-1].quo[FRACTION_BITS-2:0], quo_bit};
    end
  end

  for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_stage
    logic vld_in;
    if (k == 0) begin : g_first
      assign vld_in = in_valid_i;
    end else begin : g_rest
      assign vld_in = vld_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // output stage
  logic [GRADE_WIDTH-1:0] grade_d, grade_q;
  logic                   supp_q;

  always_comb begin
    case (stg_q[DIV_STAGES].mode)
      MODE_FULL: grade_d = GRADE_ONE;
      MODE_DIV:  grade_d = {1'b0, stg_q[DIV_STAGES].quo};
      default:   grade_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grade_q <= grade_d;
      supp_q  <= stg_q[DIV_STAGES].in_support;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign grade_o      = grade_q;
  assign in_support_o = supp_q;

endmodule
